/* hdl/lltd_pkg.sv */
package lltd_pkg;

    localparam int BYTE_W   = 8;
    localparam int TAG_W    = 32;
    localparam int RULE_W   = 16;
    localparam int OFS_W    = 16;
    localparam int TYPE_W   = 7;
    localparam int LEN_W    = 9;
    localparam int WORD_W   = 32;

    // tlv type codes: the end marker and the types that get decoded fields
    localparam logic [TYPE_W-1:0] TYPE_END        = 7'd0;
    localparam logic [TYPE_W-1:0] TYPE_CHASSIS_ID = 7'd1;
    localparam logic [TYPE_W-1:0] TYPE_PORT_ID    = 7'd2;
    localparam logic [TYPE_W-1:0] TYPE_TTL        = 7'd3;
    localparam logic [TYPE_W-1:0] TYPE_SYS_CAP    = 7'd7;
    localparam logic [TYPE_W-1:0] TYPE_MGMT_ADDR  = 7'd8;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_VALUE,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [TAG_W-1:0]  packet_tag_out;
        logic [RULE_W-1:0] rule_tag_out;
        logic [OFS_W-1:0]  tlv_seq;
        logic [TYPE_W-1:0] tlv_kind;
        logic [LEN_W-1:0]  tlv_len;
        logic [OFS_W-1:0]  value_ofs;
        logic [BYTE_W-1:0] subtype;
        logic [15:0]       ttl_value;
        logic [WORD_W-1:0] capabilities;
        logic [BYTE_W-1:0] ma_addr_subtype;
        logic [BYTE_W-1:0] ma_if_subtype;
        logic [WORD_W-1:0] ma_if_number;
    } row_t;

endpackage

/* hdl/lltd_if.sv */
interface lltd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [lltd_pkg::BYTE_W-1:0] data_byte;
    logic                        region_end;
    logic [lltd_pkg::TAG_W-1:0]  packet_tag;
    logic [lltd_pkg::RULE_W-1:0] rule_tag;

    modport source (output valid, data_byte, region_end, packet_tag, rule_tag, input ready);
    modport sink   (input valid, data_byte, region_end, packet_tag, rule_tag, output ready);
endinterface

interface lltd_row_if;
    logic                        valid;
    logic                        ready;
    logic [lltd_pkg::TAG_W-1:0]  packet_tag_out;
    logic [lltd_pkg::RULE_W-1:0] rule_tag_out;
    logic [lltd_pkg::OFS_W-1:0]  tlv_seq;
    logic [lltd_pkg::TYPE_W-1:0] tlv_kind;
    logic [lltd_pkg::LEN_W-1:0]  tlv_len;
    logic [lltd_pkg::OFS_W-1:0]  value_ofs;
    logic [lltd_pkg::BYTE_W-1:0] subtype;
    logic [15:0]                 ttl_value;
    logic [lltd_pkg::WORD_W-1:0] capabilities;
    logic [lltd_pkg::BYTE_W-1:0] ma_addr_subtype;
    logic [lltd_pkg::BYTE_W-1:0] ma_if_subtype;
    logic [lltd_pkg::WORD_W-1:0] ma_if_number;

    modport source (output valid, packet_tag_out, rule_tag_out, tlv_seq, tlv_kind,
                    tlv_len, value_ofs, subtype, ttl_value, capabilities,
                    ma_addr_subtype, ma_if_subtype, ma_if_number,
                    input ready);
    modport sink   (input valid, packet_tag_out, rule_tag_out, tlv_seq, tlv_kind,
                    tlv_len, value_ofs, subtype, ttl_value, capabilities,
                    ma_addr_subtype, ma_if_subtype, ma_if_number,
                    output ready);
endinterface

/* hdl/lldp_tlv_decoder.sv */
// lldp tlv decoder: takes an lldp payload region one byte per transfer (region_end on the
// final byte) and walks its tlvs (7-bit type, 9-bit length, msb first). one row comes out
// for each non-end tlv whose value is complete, on the byte that completes it (the second header
// byte for a zero-length tlv), with the running tlv index, header fields, value offset
// and decoded fields for chassis id, port id, ttl, capabilities and management address.
// an end tlv (type 0) or a truncated tlv stops the walk until the region's final byte.
// every byte is handled in one pass of logic between the walk state and the row output
// register, so the block takes one byte per cycle and a row appears in the cycle after the
// byte that completes it; it only holds input back while a finished row waits to be taken.
module lldp_tlv_decoder (
    input  logic        clk,
    input  logic        rst_n,
    lltd_byte_if.sink   bytes,
    lltd_row_if.source  rows
);

    // walk state
    lltd_pkg::phase_t             phase_reg, phase_next;
    logic [lltd_pkg::OFS_W-1:0]   region_offset_reg, region_offset_next;
    logic [lltd_pkg::OFS_W-1:0]   tlv_count_reg, tlv_count_next;
    logic [lltd_pkg::TYPE_W-1:0]  cur_type_reg, cur_type_next;
    logic [lltd_pkg::LEN_W-1:0]   cur_length_reg, cur_length_next;
    logic [lltd_pkg::LEN_W-1:0]   value_count_reg, value_count_next;
    logic [lltd_pkg::OFS_W-1:0]   value_start_reg, value_start_next;
    logic [lltd_pkg::BYTE_W-1:0]  first_byte_reg, first_byte_next;
    logic [lltd_pkg::BYTE_W-1:0]  second_byte_reg, second_byte_next;
    logic [lltd_pkg::WORD_W-1:0]  word_gather_reg, word_gather_next;
    logic [lltd_pkg::BYTE_W-1:0]  iface_sub_reg, iface_sub_next;
    logic [lltd_pkg::WORD_W-1:0]  iface_num_reg, iface_num_next;

    // row output register
    logic                         out_valid_reg;
    lltd_pkg::row_t               row_reg;
    lltd_pkg::row_t               row_next;

    logic                         byte_accept;
    logic                         row_emit;

    // wide copies for the address-length window compares
    logic [lltd_pkg::LEN_W:0]     vcount_w;
    logic [lltd_pkg::LEN_W:0]     alen_w;
    logic [lltd_pkg::LEN_W:0]     new_alen_w;

    // a new byte is taken whenever the output register is empty or being drained
    assign bytes.ready = !out_valid_reg || rows.ready;
    assign byte_accept = bytes.valid && bytes.ready;

    assign vcount_w   = {1'b0, value_count_reg};
    assign alen_w     = {2'b00, first_byte_reg};
    assign new_alen_w = {2'b00, first_byte_next};

    // next walk state and row strobe
    always_comb
    begin
        phase_next         = phase_reg;
        region_offset_next = region_offset_reg;
        tlv_count_next     = tlv_count_reg;
        cur_type_next      = cur_type_reg;
        cur_length_next    = cur_length_reg;
        value_count_next   = value_count_reg;
        value_start_next   = value_start_reg;
        first_byte_next    = first_byte_reg;
        second_byte_next   = second_byte_reg;
        word_gather_next   = word_gather_reg;
        iface_sub_next     = iface_sub_reg;
        iface_num_next     = iface_num_reg;
        row_emit           = 1'b0;

        case (phase_reg)
            lltd_pkg::PH_HDR0:
            begin
                cur_type_next   = bytes.data_byte[7:1];
                cur_length_next = {bytes.data_byte[0], 8'h00};
                phase_next      = lltd_pkg::PH_HDR1;
            end
            lltd_pkg::PH_HDR1:
            begin
                cur_length_next  = {cur_length_reg[8], bytes.data_byte};
                value_count_next = '0;
                first_byte_next  = '0;
                second_byte_next = '0;
                word_gather_next = '0;
                iface_sub_next   = '0;
                iface_num_next   = '0;
                value_start_next = region_offset_reg + 16'd1;
                if (cur_type_reg == lltd_pkg::TYPE_END)
                begin
                    phase_next = lltd_pkg::PH_STOP;
                end
                else if (cur_length_next == '0)
                begin
                    row_emit   = 1'b1;
                    phase_next = lltd_pkg::PH_HDR0;
                end
                else
                begin
                    phase_next = lltd_pkg::PH_VALUE;
                end
            end
            lltd_pkg::PH_VALUE:
            begin
                if (value_count_reg == 9'd0)
                    first_byte_next = bytes.data_byte;
                if (value_count_reg == 9'd1)
                    second_byte_next = bytes.data_byte;
                if (value_count_reg < 9'd4)
                    word_gather_next = {word_gather_reg[23:0], bytes.data_byte};
                // interface subtype and number sit right after the management address
                if (value_count_reg != 9'd0 && first_byte_reg != 8'd0)
                begin
                    if (vcount_w == alen_w + 10'd1)
                        iface_sub_next = bytes.data_byte;
                    else if (vcount_w >= alen_w + 10'd2 && vcount_w <= alen_w + 10'd5)
                        iface_num_next = {iface_num_reg[23:0], bytes.data_byte};
                end
                value_count_next = value_count_reg + 9'd1;
                if (value_count_next == cur_length_reg)
                begin
                    row_emit   = 1'b1;
                    phase_next = lltd_pkg::PH_HDR0;
                end
            end
            default:
            begin
                // stopped: bytes are ignored until the region ends
            end
        endcase

        if (row_emit && tlv_count_reg != 16'hFFFF)
            tlv_count_next = tlv_count_reg + 16'd1;

        // the final byte restarts the walk for the next region
        if (bytes.region_end)
        begin
            phase_next         = lltd_pkg::PH_HDR0;
            region_offset_next = '0;
            tlv_count_next     = '0;
        end
        else
        begin
            region_offset_next = region_offset_reg + 16'd1;
        end
    end

    // row fields, decoded from the state after this byte
    always_comb
    begin
        row_next                    = '0;
        row_next.packet_tag_out     = bytes.packet_tag;
        row_next.rule_tag_out       = bytes.rule_tag;
        row_next.tlv_seq            = tlv_count_reg;
        row_next.tlv_kind           = cur_type_next;
        row_next.tlv_len            = cur_length_next;
        if (cur_length_next != '0)
            row_next.value_ofs = value_start_next;
        if ((cur_type_next inside {lltd_pkg::TYPE_CHASSIS_ID, lltd_pkg::TYPE_PORT_ID})
            && cur_length_next >= 9'd1)
            row_next.subtype = first_byte_next;
        if (cur_type_next == lltd_pkg::TYPE_TTL && cur_length_next >= 9'd2)
            row_next.ttl_value = {first_byte_next, second_byte_next};
        if (cur_type_next == lltd_pkg::TYPE_SYS_CAP && cur_length_next >= 9'd4)
            row_next.capabilities = word_gather_next;
        if (cur_type_next == lltd_pkg::TYPE_MGMT_ADDR)
        begin
            if (cur_length_next >= 9'd2)
                row_next.ma_addr_subtype = second_byte_next;
            // interface fields only when the address is non-empty and fully followed
            if (cur_length_next != '0 && first_byte_next != 8'd0
                && {1'b0, cur_length_next} >= new_alen_w + 10'd6)
            begin
                row_next.ma_if_subtype = iface_sub_next;
                row_next.ma_if_number  = iface_num_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= lltd_pkg::PH_HDR0;
            region_offset_reg <= '0;
            tlv_count_reg     <= '0;
            cur_type_reg      <= '0;
            cur_length_reg    <= '0;
            value_count_reg   <= '0;
            value_start_reg   <= '0;
            first_byte_reg    <= '0;
            second_byte_reg   <= '0;
            word_gather_reg   <= '0;
            iface_sub_reg     <= '0;
            iface_num_reg     <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg         <= phase_next;
            region_offset_reg <= region_offset_next;
            tlv_count_reg     <= tlv_count_next;
            cur_type_reg      <= cur_type_next;
            cur_length_reg    <= cur_length_next;
            value_count_reg   <= value_count_next;
            value_start_reg   <= value_start_next;
            first_byte_reg    <= first_byte_next;
            second_byte_reg   <= second_byte_next;
            word_gather_reg   <= word_gather_next;
            iface_sub_reg     <= iface_sub_next;
            iface_num_reg     <= iface_num_next;
        end
    end

    // output valid: loaded on every accepted byte, dropped when the row is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (byte_accept)
            out_valid_reg <= row_emit;
        else if (rows.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && row_emit)
            row_reg <= row_next;
    end

    assign rows.valid           = out_valid_reg;
    assign rows.packet_tag_out  = row_reg.packet_tag_out;
    assign rows.rule_tag_out    = row_reg.rule_tag_out;
    assign rows.tlv_seq         = row_reg.tlv_seq;
    assign rows.tlv_kind        = row_reg.tlv_kind;
    assign rows.tlv_len         = row_reg.tlv_len;
    assign rows.value_ofs       = row_reg.value_ofs;
    assign rows.subtype         = row_reg.subtype;
    assign rows.ttl_value       = row_reg.ttl_value;
    assign rows.capabilities    = row_reg.capabilities;
    assign rows.ma_addr_subtype = row_reg.ma_addr_subtype;
    assign rows.ma_if_subtype   = row_reg.ma_if_subtype;
    assign rows.ma_if_number    = row_reg.ma_if_number;

endmodule

/* hdl/lltd_checker.sv */
module lltd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lltd_pkg::TYPE_W-1:0] tlv_kind,
    input logic [15:0]                 ttl_value,
    input logic [lltd_pkg::BYTE_W-1:0] ma_addr_subtype,
    input logic [lltd_pkg::BYTE_W-1:0] ma_if_subtype,
    input logic [lltd_pkg::WORD_W-1:0] ma_if_number
);

    // a waiting row is not withdrawn
    a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("row dropped while stalled");

    // a new row only follows an accepted byte
    a_row_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("row appeared without a byte transfer");

    // ttl decode only for ttl tlvs
    a_ttl_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tlv_kind != lltd_pkg::TYPE_TTL |-> ttl_value == 16'd0)
        else $error("ttl set on a non-ttl row");

    // management fields only for management address tlvs
    a_mgmt_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tlv_kind != lltd_pkg::TYPE_MGMT_ADDR |->
            ma_addr_subtype == 8'd0 && ma_if_subtype == 8'd0
            && ma_if_number == 32'd0)
        else $error("management fields set on another tlv type");

endmodule

bind lldp_tlv_decoder lltd_checker u_lltd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (bytes.valid),
    .in_ready        (bytes.ready),
    .out_valid       (rows.valid),
    .out_ready       (rows.ready),
    .tlv_kind        (rows.tlv_kind),
    .ttl_value       (rows.ttl_value),
    .ma_addr_subtype (rows.ma_addr_subtype),
    .ma_if_subtype   (rows.ma_if_subtype),
    .ma_if_number    (rows.ma_if_number)
);
